// ===== hdl/thruster_mixer_normalizer_macros.svh =====
// Assertion macros shared by the thruster mixer RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef THRUSTER_MIXER_NORMALIZER_MACROS_SVH
`define THRUSTER_MIXER_NORMALIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define TMN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition in one cycle that implies a consequence in the next.
`define TMN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define TMN_ASSERT(label, prop, msg)
`define TMN_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/tmn_pkg.sv =====
// Shared types and constants for the thruster mixer and normalizer.
// No dependencies; the coefficient memory, lane, merge and top-level modules import it.
package tmn_pkg;

   localparam int TMN_THRUSTERS = 8;
   localparam int TMN_NEUTRAL   = 1500;
   localparam int TMN_AXES      = 6;
   localparam int TMN_SLOTS     = 8;
   localparam int TMN_FRAC      = 13;

   // Item opcodes.
   typedef enum logic [1:0] {
      OP_COEF   = 2'd0,
      OP_MIX    = 2'd1,
      OP_ARM    = 2'd2,
      OP_DISARM = 2'd3
   } op_type;

   // Register indexes of the configuration port.
   localparam logic [3:0] CSR_MIN_PULSE = 4'd0;
   localparam logic [3:0] CSR_MAX_PULSE = 4'd1;

   typedef logic signed [23:0] sum_type;
   typedef logic signed [34:0] acc_type;

   // One pulse handed from the normalizer to the output register.
   typedef struct packed {
      logic        valid;
      logic [2:0]  index;
      logic [11:0] pulse;
      logic        last;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_NORM,
      ST_NEUT,
      ST_REFUSE
   } top_state_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_SCAN,
      M_MUL,
      M_DIV,
      M_OUT
   } merge_state_type;

endpackage

// ===== hdl/tmn_req_if.sv =====
// Input channel of the thruster mixer: valid/ready plus one item.
// Depends on nothing.
interface tmn_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] surge_cmd;
   logic signed [15:0] sway_cmd;
   logic signed [15:0] heave_cmd;
   logic signed [15:0] roll_cmd;
   logic signed [15:0] pitch_cmd;
   logic signed [15:0] yaw_cmd;
   logic [2:0]         coef_axis;
   logic [2:0]         coef_thruster;
   logic signed [15:0] coef_value;

   modport source (output valid, opcode, surge_cmd, sway_cmd, heave_cmd, roll_cmd,
                   pitch_cmd, yaw_cmd, coef_axis, coef_thruster, coef_value,
                   input ready);
   modport sink (input valid, opcode, surge_cmd, sway_cmd, heave_cmd, roll_cmd,
                 pitch_cmd, yaw_cmd, coef_axis, coef_thruster, coef_value,
                 output ready);
endinterface

// ===== hdl/tmn_rsp_if.sv =====
// Result channel of the thruster mixer: valid/ready plus one pulse.
// Depends on nothing.
interface tmn_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  thruster_index;
   logic [11:0] pulse_us;
   logic        refused;
   logic        last;

   modport source (output valid, thruster_index, pulse_us, refused, last, input ready);
   modport sink (input valid, thruster_index, pulse_us, refused, last, output ready);
endinterface

// ===== hdl/tmn_csr_if.sv =====
// Configuration write channel of the thruster mixer.
// Depends on nothing.
interface tmn_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/tmn_coef_mem.sv =====
// Coefficient table: one row per axis, one column per thruster slot.
// Uses tmn_pkg. Entries never written read as zero through valid bits.
module tmn_coef_mem #(
   parameter int THRUSTER_COUNT = tmn_pkg::TMN_THRUSTERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [2:0]         wr_axis,
   input  logic [2:0]         wr_thr,
   input  logic signed [15:0] wr_val,
   input  logic               rd_en,
   input  logic [2:0]         rd_axis,
   output logic signed [15:0] rd_coef [tmn_pkg::TMN_SLOTS]
);
   import tmn_pkg::*;

   // Each axis row is one wide word; a write updates one column of it.
   logic [TMN_SLOTS-1:0][15:0] mem_ff   [TMN_AXES];
   logic [TMN_SLOTS-1:0]       valid_ff [TMN_AXES];
   logic signed [15:0]         rd_ff    [TMN_SLOTS];
   logic [TMN_SLOTS-1:0][15:0] rd_row;
   logic [TMN_SLOTS-1:0]       rd_vld;
   logic                       wr_ok;

   // Writes outside the axis rows or the fitted thrusters are dropped.
   assign wr_ok = wr_en && (wr_axis < 3'(TMN_AXES))
                  && ({1'b0, wr_thr} < 4'(THRUSTER_COUNT));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_axis][wr_thr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < TMN_AXES; a++) begin
            valid_ff[a] <= '0;
         end
      end else if (wr_ok) begin
         valid_ff[wr_axis][wr_thr] <= 1'b1;
      end
   end

   // One row address per cycle.
   assign rd_row = mem_ff[rd_axis];
   assign rd_vld = valid_ff[rd_axis];

   // Registered row read; an unwritten entry reads as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int j = 0; j < TMN_SLOTS; j++) begin
            rd_ff[j] <= rd_vld[j] ? rd_row[j] : 16'd0;
         end
      end
   end

   assign rd_coef = rd_ff;
endmodule

// ===== hdl/tmn_lane.sv =====
// One thruster lane: accumulates axis command times coefficient.
// Uses tmn_pkg. Result is the sum scaled by 2^-13, truncated toward zero.
module tmn_lane (
   input  logic               clock,
   input  logic               clear,
   input  logic               mac_en,
   input  logic signed [15:0] cmd,
   input  logic signed [15:0] coef,
   output tmn_pkg::sum_type   sum
);
   import tmn_pkg::*;

   acc_type acc_ff;
   acc_type acc_in;
   acc_type bias;
   acc_type shifted;

   // Multiply and accumulate one axis per cycle while mac_en is high.
   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (mac_en) begin
         acc_in = acc_ff + 35'(cmd * coef);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round toward zero: negative sums get the fraction bias before the shift.
   assign bias    = acc_ff[34] ? acc_type'((1 << TMN_FRAC) - 1) : '0;
   assign shifted = (acc_ff + bias) >>> TMN_FRAC;
   assign sum     = shifted[23:0];
endmodule

// ===== hdl/tmn_merge.sv =====
// Merge stage: min/max over the lane sums, then linear scaling per thruster.
// Uses tmn_pkg and the assertion macros; the scaling divide runs bit-serially.
`include "thruster_mixer_normalizer_macros.svh"
module tmn_merge #(
   parameter int THRUSTER_COUNT = tmn_pkg::TMN_THRUSTERS,
   parameter int NEUTRAL_PULSE  = tmn_pkg::TMN_NEUTRAL
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tmn_pkg::sum_type sums [tmn_pkg::TMN_SLOTS],
   input  logic [11:0]      min_pulse,
   input  logic [11:0]      max_pulse,
   input  logic             take,
   output tmn_pkg::res_type res
);
   import tmn_pkg::*;

   localparam logic [2:0]  LAST_T = 3'(THRUSTER_COUNT - 1);
   localparam logic [11:0] NEUT_P = 12'(NEUTRAL_PULSE);

   merge_state_type st_ff, st_in;
   logic [2:0]  idx_ff, idx_in;
   sum_type     lo_ff, lo_in, hi_ff, hi_in;
   logic [36:0] rem_ff, rem_in;
   logic [24:0] den_ff, den_in;
   logic [11:0] q_ff, q_in;
   logic [3:0]  it_ff, it_in;
   logic        neg_ff, neg_in, spec_ff, spec_in;

   sum_type            cur;
   logic [24:0]        diff;
   logic signed [12:0] rng;
   logic [11:0]        rmag;
   logic [36:0]        num;
   logic [36:0]        dsh;
   logic signed [13:0] qs, val, pmin_s, pmax_s;
   logic [11:0]        pulse;

   assign cur  = sums[idx_ff];
   assign diff = {cur[23], cur} - {lo_ff[23], lo_ff};
   assign rng  = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
   assign rmag = rng[12] ? 12'(-rng) : rng[11:0];
   assign num  = {12'b0, diff} * {25'b0, rmag};
   assign dsh  = {12'b0, den_ff} << it_ff;

   // Signed quotient plus offset, then clamp in the order low, high; a special case gives the neutral pulse.
   assign pmin_s = $signed({2'b0, min_pulse});
   assign pmax_s = $signed({2'b0, max_pulse});
   assign qs     = neg_ff ? -$signed({2'b0, q_ff}) : $signed({2'b0, q_ff});
   assign val    = qs + pmin_s;
   always_comb begin
      if (spec_ff) begin
         pulse = NEUT_P;
      end else if (val < pmin_s) begin
         pulse = min_pulse;
      end else if (val > pmax_s) begin
         pulse = max_pulse;
      end else begin
         pulse = val[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      it_ff   <= it_in;
      neg_ff  <= neg_in;
      spec_ff <= spec_in;
   end

   // Next state and datapath control.
   always_comb begin
      st_in   = st_ff;
      idx_in  = idx_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      it_in   = it_ff;
      neg_in  = neg_ff;
      spec_in = spec_ff;
      res     = '0;
      case (st_ff)
         M_IDLE: begin
            if (start) begin
               idx_in = '0;
               st_in  = M_SCAN;
            end
         end
         M_SCAN: begin
            if (idx_ff == 3'd0 || cur < lo_ff) begin
               lo_in = cur;
            end
            if (idx_ff == 3'd0 || cur > hi_ff) begin
               hi_in = cur;
            end
            if (idx_ff == LAST_T) begin
               idx_in = '0;
               st_in  = M_MUL;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         M_MUL: begin
            rem_in  = num;
            den_in  = {hi_ff[23], hi_ff} - {lo_ff[23], lo_ff};
            neg_in  = rng[12];
            spec_in = (cur == '0) || (lo_ff == hi_ff);
            q_in    = '0;
            it_in   = 4'd11;
            st_in   = spec_in ? M_OUT : M_DIV;
         end
         M_DIV: begin
            // Quotient never exceeds 4095, so twelve restoring steps suffice.
            if (rem_ff >= dsh) begin
               rem_in       = rem_ff - dsh;
               q_in[it_ff]  = 1'b1;
            end
            if (it_ff == 4'd0) begin
               st_in = M_OUT;
            end else begin
               it_in = it_ff - 4'd1;
            end
         end
         M_OUT: begin
            res.valid = 1'b1;
            res.index = idx_ff;
            res.pulse = pulse;
            res.last  = (idx_ff == LAST_T);
            if (take) begin
               if (idx_ff == LAST_T) begin
                  st_in = M_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  st_in  = M_MUL;
               end
            end
         end
         default: begin
            st_in = M_IDLE;
         end
      endcase
   end

   `TMN_ASSERT(a_extremes_ordered, (st_ff == M_MUL) |-> (lo_ff <= hi_ff), "min above max")
   `TMN_ASSERT(a_div_nonzero, (st_ff == M_DIV) |-> (den_ff != '0), "divide by zero")
   `TMN_ASSERT(a_rem_bound, (st_ff == M_OUT && !spec_ff) |-> (rem_ff < {12'b0, den_ff}),
               "remainder not below divisor")
endmodule

// ===== hdl/thruster_mixer_normalizer.sv =====
// Top level of the thruster mixer and normalizer: control, lanes, output register.
// Uses tmn_pkg, the channel interfaces, tmn_coef_mem, tmn_lane and tmn_merge.
//
//   channel  direction  payload
//   req_ch   in         opcode, six axis commands, coefficient address and value
//   rsp_ch   out        thruster_index, pulse_us, refused, last
//   csr_ch   in         index, data (min_pulse, max_pulse)
//
// Coefficient writes and arm produce no result; disarm sends a neutral pulse for
// every fitted thruster and a refused mix sends a single refused result. An armed
// mix accumulates the six axes, then the merge stage scans the sums and runs the
// twelve-step divider, which it shares across thrusters, for each non-neutral result.
// Reset is synchronous; it clears the coefficient valid bits and the armed flag and
// restores the pulse range. A stalled result holds the block.
`include "thruster_mixer_normalizer_macros.svh"
module thruster_mixer_normalizer #(
   parameter int THRUSTER_COUNT = tmn_pkg::TMN_THRUSTERS,
   parameter int NEUTRAL_PULSE  = tmn_pkg::TMN_NEUTRAL
) (
   input  logic      clock,
   input  logic      reset,
   tmn_req_if.sink   req_ch,
   tmn_rsp_if.source rsp_ch,
   tmn_csr_if.sink   csr_ch
);
   import tmn_pkg::*;

   localparam logic [2:0]  LAST_T = 3'(THRUSTER_COUNT - 1);
   localparam logic [11:0] NEUT_P = 12'(NEUTRAL_PULSE);

   top_state_type st_ff, st_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        armed_ff, armed_in;
   logic [11:0] min_pulse_ff, max_pulse_ff;
   logic signed [15:0] cmd_ff [TMN_AXES];
   logic        mac_vld_ff;
   logic [2:0]  mac_axis_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic [11:0] rsp_pulse_ff, rsp_pulse_in;
   logic        rsp_refused_ff, rsp_refused_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_acc, slot_free, rd_en, merge_start, merge_take;
   op_type      op;
   logic signed [15:0] coef_row [TMN_SLOTS];
   sum_type     sums [TMN_SLOTS];
   res_type     mres;

   assign op        = op_type'(req_ch.opcode);
   assign req_ch.ready = (st_ff == ST_IDLE);
   assign req_acc   = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign rd_en     = (st_ff == ST_MAC) && (cnt_ff < 3'(TMN_AXES));

   // Configuration registers.
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= 12'd1100;
         max_pulse_ff <= 12'd1900;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_MIN_PULSE) begin
            min_pulse_ff <= csr_ch.data[11:0];
         end else if (csr_ch.index == CSR_MAX_PULSE) begin
            max_pulse_ff <= csr_ch.data[11:0];
         end
      end
   end

   // Axis commands of a mix transaction.
   always_ff @(posedge clock) begin
      if (req_acc && op == OP_MIX) begin
         cmd_ff[0] <= req_ch.surge_cmd;
         cmd_ff[1] <= req_ch.sway_cmd;
         cmd_ff[2] <= req_ch.heave_cmd;
         cmd_ff[3] <= req_ch.roll_cmd;
         cmd_ff[4] <= req_ch.pitch_cmd;
         cmd_ff[5] <= req_ch.yaw_cmd;
      end
   end

   // Row read of the table is registered; the lane update follows in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_vld_ff <= 1'b0;
      end else begin
         mac_vld_ff <= rd_en;
      end
   end
   always_ff @(posedge clock) begin
      mac_axis_ff <= cnt_ff;
   end

   tmn_coef_mem #(.THRUSTER_COUNT(THRUSTER_COUNT)) u_coef (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_acc && op == OP_COEF),
      .wr_axis (req_ch.coef_axis),
      .wr_thr  (req_ch.coef_thruster),
      .wr_val  (req_ch.coef_value),
      .rd_en   (rd_en),
      .rd_axis (cnt_ff),
      .rd_coef (coef_row)
   );

   // One lane per fitted thruster; unused slots read as zero.
   for (genvar g = 0; g < TMN_SLOTS; g++) begin : g_lane
      if (g < THRUSTER_COUNT) begin : g_on
         tmn_lane u_lane (
            .clock  (clock),
            .clear  (req_acc && op == OP_MIX),
            .mac_en (mac_vld_ff),
            .cmd    (cmd_ff[mac_axis_ff]),
            .coef   (coef_row[g]),
            .sum    (sums[g])
         );
      end else begin : g_off
         assign sums[g] = '0;
      end
   end

   tmn_merge #(
      .THRUSTER_COUNT (THRUSTER_COUNT),
      .NEUTRAL_PULSE  (NEUTRAL_PULSE)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (merge_start),
      .sums      (sums),
      .min_pulse (min_pulse_ff),
      .max_pulse (max_pulse_ff),
      .take      (merge_take),
      .res       (mres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Sequencer and output register loading.
   always_comb begin
      st_in          = st_ff;
      cnt_in         = cnt_ff;
      armed_in       = armed_ff;
      merge_start    = 1'b0;
      merge_take     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in     = rsp_idx_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_last_in    = rsp_last_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in = '0;
               case (op)
                  OP_ARM: begin
                     armed_in = 1'b1;
                  end
                  OP_DISARM: begin
                     armed_in = 1'b0;
                     st_in    = ST_NEUT;
                  end
                  OP_MIX: begin
                     st_in = armed_ff ? ST_MAC : ST_REFUSE;
                  end
                  default: begin
                     st_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MAC: begin
            if (cnt_ff == 3'(TMN_AXES)) begin
               merge_start = 1'b1;
               st_in       = ST_NORM;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_NORM: begin
            if (mres.valid && slot_free) begin
               merge_take     = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_idx_in     = mres.index;
               rsp_pulse_in   = mres.pulse;
               rsp_refused_in = 1'b0;
               rsp_last_in    = mres.last;
               if (mres.last) begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_NEUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_idx_in     = cnt_ff;
               rsp_pulse_in   = NEUT_P;
               rsp_refused_in = 1'b0;
               rsp_last_in    = (cnt_ff == LAST_T);
               cnt_in         = cnt_ff + 3'd1;
               if (cnt_ff == LAST_T) begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_REFUSE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_idx_in     = '0;
               rsp_pulse_in   = '0;
               rsp_refused_in = 1'b1;
               rsp_last_in    = 1'b1;
               st_in          = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.thruster_index = rsp_idx_ff;
   assign rsp_ch.pulse_us       = rsp_pulse_ff;
   assign rsp_ch.refused        = rsp_refused_ff;
   assign rsp_ch.last           = rsp_last_ff;

   `TMN_ASSERT_NEXT(a_disarm_clears, req_acc && op == OP_DISARM, !armed_ff,
                    "disarm left the block armed")
   `TMN_ASSERT(a_refused_form, (rsp_valid_ff && rsp_refused_ff) |->
               (rsp_last_ff && rsp_pulse_ff == '0 && rsp_idx_ff == '0), "bad refused result")
   `TMN_ASSERT(a_index_range, rsp_valid_ff |-> ({1'b0, rsp_idx_ff} < 4'(THRUSTER_COUNT)),
               "thruster index out of range")
endmodule
